// ===== src/lifeg_pkg.sv =====
package lifeg_pkg;

	// Default grid size.
	localparam int GRID_W_DFLT = 64;
	localparam int GRID_H_DFLT = 64;

	// Field widths of the command word.
	localparam int CMD_W = 2;
	localparam int POS_W = 6;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

	// Life rule B3/S23.
	localparam logic [3:0] LIFE_BIRTH   = 4'd3;
	localparam logic [3:0] LIFE_SURVIVE = 4'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             write_alive;
	} req_word_t;

	typedef struct packed {
		logic read_alive;
		logic op_done;
	} rsp_word_t;

	// Eight neighbours around one cell, in row order, the cell itself left out.
	typedef struct packed {
		logic [2:0] up;
		logic [1:0] mid;
		logic [2:0] dn;
	} nbr_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_MODIFY,
		ST_ADV_START,
		ST_ADV_FIRST,
		ST_ADV_FETCH,
		ST_ADV_LOAD,
		ST_ADV_CELL,
		ST_ADV_WB,
		ST_DONE
	} state_t;

endpackage

// ===== src/lifeg_stream_if.sv =====
interface lifeg_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/lifeg_ram.sv =====
module lifeg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/lifeg_rule.sv =====
module lifeg_rule (
	input  lifeg_pkg::nbr_t nbr,
	input  logic            self_alive,
	output logic            next_alive
);
	import lifeg_pkg::*;

	logic [3:0] count;

	always_comb begin
		count = 4'($countones(nbr));
		if (self_alive) begin
			next_alive = (count == LIFE_SURVIVE) || (count == LIFE_BIRTH);
		end else begin
			next_alive = (count == LIFE_BIRTH);
		end
	end
endmodule

// ===== src/life_automaton_grid_unit.sv =====
// Channel | Role   | Word fields
// req     | sink   | cmd, pos_x, pos_y, write_alive
// rsp     | source | read_alive, op_done
//
// After reset the grid rows are cleared one per cycle with req.ready low.
// A read or a write passes through the access, modify and done states before the response
// register is loaded; a position outside the grid or an unused code skips the modify state.
// During an advance the single rule unit sees one cell
// per cycle, and each row costs one fetch, one load and one write-back of the row memory.
// A waiting response does not block the next command; the block only holds in its final
// state when the response register is still full and not being taken.
module life_automaton_grid_unit #(
	parameter int GRID_W = lifeg_pkg::GRID_W_DFLT,
	parameter int GRID_H = lifeg_pkg::GRID_H_DFLT
) (
	input  logic           clk,
	input  logic           arst_n,
	lifeg_stream_if.sink   req,
	lifeg_stream_if.source rsp
);
	import lifeg_pkg::*;

	localparam int XW  = $clog2(GRID_W);
	localparam int YW  = $clog2(GRID_H);
	localparam int XCW = ((XW > POS_W) ? XW : POS_W) + 1;
	localparam int YCW = ((YW > POS_W) ? YW : POS_W) + 1;
	localparam logic [XW-1:0] X_LAST = XW'(GRID_W - 1);
	localparam logic [YW-1:0] Y_LAST = YW'(GRID_H - 1);

	state_t state_q, state_d;

	req_word_t   req_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic          rd_q;

	// Sliding window of three rows for the advance sweep, and the row being built.
	logic [GRID_W-1:0] row_up_q, row_mid_q, row_dn_q, new_row_q;

	logic              rsp_valid_q;
	rsp_word_t         rsp_word_q;

	logic              mem_we, mem_re;
	logic [YW-1:0]     mem_waddr, mem_raddr;
	logic [GRID_W-1:0] mem_wdata, mem_rdata;

	logic              on_grid;
	logic [XW-1:0]     px, x_dec, x_inc;
	logic              at_left, at_right;
	nbr_t              nbr;
	logic              cell_next;
	logic              rsp_free;
	logic [GRID_W-1:0] mod_row;

	lifeg_ram #(
		.WIDTH(GRID_W),
		.DEPTH(GRID_H)
	) u_grid (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	lifeg_rule u_rule (
		.nbr       (nbr),
		.self_alive(row_mid_q[x_q]),
		.next_alive(cell_next)
	);

	// Position check against the grid bounds; the field may be narrower or wider.
	assign on_grid = (XCW'(req_q.pos_x) < XCW'(GRID_W)) && (YCW'(req_q.pos_y) < YCW'(GRID_H));
	assign px      = XW'(req_q.pos_x);

	// Neighbour window for the cell under the sweep; outside the grid counts as dead.
	assign at_left  = (x_q == '0);
	assign at_right = (x_q == X_LAST);
	assign x_dec    = x_q - 1'b1;
	assign x_inc    = x_q + 1'b1;

	always_comb begin
		nbr.up[2]  = at_left  ? 1'b0 : row_up_q[x_dec];
		nbr.up[1]  = row_up_q[x_q];
		nbr.up[0]  = at_right ? 1'b0 : row_up_q[x_inc];
		nbr.mid[1] = at_left  ? 1'b0 : row_mid_q[x_dec];
		nbr.mid[0] = at_right ? 1'b0 : row_mid_q[x_inc];
		nbr.dn[2]  = at_left  ? 1'b0 : row_dn_q[x_dec];
		nbr.dn[1]  = row_dn_q[x_q];
		nbr.dn[0]  = at_right ? 1'b0 : row_dn_q[x_inc];
	end

	always_comb begin
		mod_row     = mem_rdata;
		mod_row[px] = req_q.write_alive;
	end

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = y_q;
		mem_wdata = new_row_q;
		mem_raddr = YW'(req_q.pos_y);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				if (y_q == Y_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					if (req.payload.cmd == CMD_ADVANCE) begin
						state_d = ST_ADV_START;
					end else begin
						state_d = ST_ACCESS;
					end
				end
			end
			ST_ACCESS: begin
				if (on_grid && (req_q.cmd inside {CMD_WRITE, CMD_READ})) begin
					mem_re  = 1'b1;
					state_d = ST_MODIFY;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MODIFY: begin
				if (req_q.cmd == CMD_WRITE) begin
					mem_we    = 1'b1;
					mem_waddr = YW'(req_q.pos_y);
					mem_wdata = mod_row;
				end
				state_d = ST_DONE;
			end
			ST_ADV_START: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
				state_d   = ST_ADV_FIRST;
			end
			ST_ADV_FIRST: begin
				state_d = ST_ADV_FETCH;
			end
			ST_ADV_FETCH: begin
				mem_re    = (y_q != Y_LAST);
				mem_raddr = y_q + 1'b1;
				state_d   = ST_ADV_LOAD;
			end
			ST_ADV_LOAD: begin
				state_d = ST_ADV_CELL;
			end
			ST_ADV_CELL: begin
				if (at_right) begin
					state_d = ST_ADV_WB;
				end
			end
			ST_ADV_WB: begin
				mem_we = 1'b1;
				if (y_q == Y_LAST) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ADV_FETCH;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0;
			x_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					y_q <= y_q + 1'b1;
				end
				ST_ADV_FIRST: begin
					y_q <= '0;
				end
				ST_ADV_LOAD: begin
					x_q <= '0;
				end
				ST_ADV_CELL: begin
					x_q <= x_q + 1'b1;
				end
				ST_ADV_WB: begin
					y_q <= y_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= req.payload;
				rd_q  <= 1'b0;
			end
			ST_MODIFY: begin
				if (req_q.cmd == CMD_READ) begin
					rd_q <= mem_rdata[px];
				end
			end
			ST_ADV_FIRST: begin
				row_up_q  <= '0;
				row_mid_q <= mem_rdata;
			end
			ST_ADV_LOAD: begin
				row_dn_q <= (y_q == Y_LAST) ? '0 : mem_rdata;
			end
			ST_ADV_CELL: begin
				new_row_q[x_q] <= cell_next;
			end
			ST_ADV_WB: begin
				row_up_q  <= row_mid_q;
				row_mid_q <= row_dn_q;
			end
			default: begin
			end
		endcase
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_word_q.read_alive <= rd_q;
			rsp_word_q.op_done    <= 1'b1;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_word_q;
endmodule

// ===== src/lifeg_checker.sv =====
module lifeg_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_read_alive,
	input logic rsp_op_done
);
	// Every response word reports completion.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_op_done)
		else $error("response word without op_done");

	// The block is not ready again in the cycle after it accepts a command.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("block ready straight after accepting a command");

	// A stalled response stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_read_alive)
			&& $stable(rsp_op_done))
		else $error("stalled response changed");

	// A response only rises when the block was not ready for commands in the cycle before.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response raised while the block was idle");
endmodule

bind life_automaton_grid_unit lifeg_checker u_lifeg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_alive(rsp.payload.read_alive),
	.rsp_op_done   (rsp.payload.op_done)
);

// ===== dv/tb_life_automaton_grid_unit.sv =====
// Shadow copy of the Life grid. Each accepted command word updates the copy
// and queues the response word the block should return for it.
class life_grid_model;
	localparam int W = lifeg_pkg::GRID_W_DFLT;
	localparam int H = lifeg_pkg::GRID_H_DFLT;

	bit cells [H][W];
	lifeg_pkg::rsp_word_t awaited [$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Anything beyond an edge reads as dead, so the grid does not wrap.
	function int unsigned cell_at(int x, int y);
		if (x < 0 || y < 0 || x >= W || y >= H)
			return 0;
		return cells[y][x];
	endfunction

	function void step_generation();
		bit nxt [H][W];
		int unsigned n;
		for (int y = 0; y < H; y++) begin
			for (int x = 0; x < W; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (dx != 0 || dy != 0)
							n += cell_at(x + dx, y + dy);
				if (cells[y][x])
					nxt[y][x] = (n == lifeg_pkg::LIFE_SURVIVE) || (n == lifeg_pkg::LIFE_BIRTH);
				else
					nxt[y][x] = (n == lifeg_pkg::LIFE_BIRTH);
			end
		end
		cells = nxt;
	endfunction

	function void note_command(lifeg_pkg::req_word_t w);
		lifeg_pkg::rsp_word_t e;
		bit on_grid;
		on_grid = (w.pos_x < W) && (w.pos_y < H);
		e.read_alive = 1'b0;
		e.op_done = 1'b1;
		case (w.cmd)
			lifeg_pkg::CMD_WRITE: begin
				if (on_grid)
					cells[w.pos_y][w.pos_x] = w.write_alive;
			end
			lifeg_pkg::CMD_READ: begin
				if (on_grid)
					e.read_alive = cells[w.pos_y][w.pos_x];
			end
			lifeg_pkg::CMD_ADVANCE: begin
				step_generation();
			end
			default: begin
			end
		endcase
		awaited.push_back(e);
	endfunction

	function void check_response(lifeg_pkg::rsp_word_t r);
		lifeg_pkg::rsp_word_t e;
		if (awaited.size() == 0) begin
			$error("response word arrived with no command outstanding");
			errors++;
			return;
		end
		e = awaited.pop_front();
		if (r.read_alive !== e.read_alive) begin
			$error("read_alive: expected %0b, actual %0b", e.read_alive, r.read_alive);
			errors++;
		end
		if (r.op_done !== e.op_done) begin
			$error("op_done: expected %0b, actual %0b", e.op_done, r.op_done);
			errors++;
		end
	endfunction

	function int outstanding();
		return awaited.size();
	endfunction
endclass

module tb_life_automaton_grid_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lifeg_pkg::*;

	// The package names no code for the fourth command value; the block must
	// treat it as a no-op that still answers.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int RANDOM_WORDS = 115;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// Settling time once the last response is in.
	localparam int TAIL_CYCLES  = 40;
	localparam int WIN_SPAN     = 8;

	logic clk = 1'b0;
	logic arst_n;

	lifeg_stream_if #(.word_t(req_word_t)) req_ch ();
	lifeg_stream_if #(.word_t(rsp_word_t)) rsp_ch ();

	life_automaton_grid_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	life_grid_model board = new();

	// Percentages of cycles in which the sender holds back and the receiver
	// refuses a word. The main sequence moves them through three phases.
	int unsigned tx_idle_pct = 38;
	int unsigned rx_idle_pct = 61;
	int unsigned cycles = 0;

	// Most random traffic lands in a small window so that the cells it writes
	// are dense enough to interact across generations. The window is moved
	// now and then, often into a corner so that the edge rules are exercised.
	int unsigned win_x = 0;
	int unsigned win_y = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog. A correct run stays well under this limit, even
	// with every advance taking its full sweep and the receiver stalling.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver refuses words at random in the proportion of the phase.
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Both channels are sampled at the rising edge, before any of this edge's
	// nonblocking updates land, so the values seen are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				board.note_command(req_ch.payload);
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_response(rsp_ch.payload);
		end
	end

	function automatic req_word_t make_word(logic [CMD_W-1:0] c, int x, int y, bit v);
		req_word_t w;
		w.cmd = c;
		w.pos_x = POS_W'(x);
		w.pos_y = POS_W'(y);
		w.write_alive = v;
		return w;
	endfunction

	function automatic void move_window();
		case ($urandom_range(3))
			0: begin
				win_x = 0;
				win_y = 0;
			end
			1: begin
				win_x = GRID_W_DFLT - WIN_SPAN;
				win_y = GRID_H_DFLT - WIN_SPAN;
			end
			2: begin
				win_x = 0;
				win_y = GRID_H_DFLT - WIN_SPAN;
			end
			default: begin
				win_x = $urandom_range(GRID_W_DFLT - WIN_SPAN);
				win_y = $urandom_range(GRID_H_DFLT - WIN_SPAN);
			end
		endcase
	endfunction

	// Mostly writes and reads inside the window, with advances frequent enough
	// that patterns evolve, and a little noise spread over the whole grid.
	function automatic req_word_t random_command();
		int unsigned pick;
		int x;
		int y;
		req_word_t w;
		pick = $urandom_range(99);
		x = win_x + $urandom_range(WIN_SPAN - 1);
		y = win_y + $urandom_range(WIN_SPAN - 1);
		w = make_word(CMD_READ, x, y, 1'($urandom_range(1)));
		if (pick < 45) begin
			w.cmd = CMD_WRITE;
			w.write_alive = ($urandom_range(9) < 7);
		end else if (pick < 52) begin
			w = make_word(CMD_WRITE, $urandom_range(63), $urandom_range(63),
				1'($urandom_range(1)));
		end else if (pick < 80) begin
			w.cmd = CMD_READ;
		end else if (pick < 87) begin
			w = make_word(CMD_READ, $urandom_range(63), $urandom_range(63),
				1'($urandom_range(1)));
		end else if (pick < 96) begin
			w = make_word(CMD_ADVANCE, $urandom_range(63), $urandom_range(63),
				1'($urandom_range(1)));
			if ($urandom_range(3) == 0)
				move_window();
		end else begin
			w = make_word(CMD_UNUSED, $urandom_range(63), $urandom_range(63),
				1'($urandom_range(1)));
		end
		return w;
	endfunction

	// Offers one word and returns at the edge where it is taken. Idle cycles
	// are inserted ahead of the word; valid is only ever assigned once per edge.
	task automatic send_word(req_word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= w;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Lowers valid and holds off until every outstanding response is back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// The four corners, two of them read back along with an inner cell, then an advance in which each lone
		// corner cell must die for want of neighbours.
		send_word(make_word(CMD_WRITE, 0, 0, 1'b1));
		send_word(make_word(CMD_WRITE, 63, 63, 1'b1));
		send_word(make_word(CMD_WRITE, 63, 0, 1'b1));
		send_word(make_word(CMD_WRITE, 0, 63, 1'b1));
		send_word(make_word(CMD_READ, 0, 0, 1'b0));
		send_word(make_word(CMD_READ, 63, 63, 1'b1));
		send_word(make_word(CMD_READ, 1, 1, 1'b1));
		send_word(make_word(CMD_ADVANCE, 0, 0, 1'b0));
		send_word(make_word(CMD_READ, 0, 0, 1'b0));

		// The unused code with every position and data bit set must leave
		// the grid alone and still answer.
		send_word(make_word(CMD_UNUSED, 63, 63, 1'b1));

		// A blinker standing against the left edge: the cells that would be
		// born beyond the edge do not exist, so only the inner one appears.
		send_word(make_word(CMD_WRITE, 0, 0, 1'b1));
		send_word(make_word(CMD_WRITE, 0, 1, 1'b1));
		send_word(make_word(CMD_WRITE, 0, 2, 1'b1));

		// A block in the far corner, which is still life even at the edge.
		send_word(make_word(CMD_WRITE, 62, 62, 1'b1));
		send_word(make_word(CMD_WRITE, 63, 62, 1'b1));
		send_word(make_word(CMD_WRITE, 62, 63, 1'b1));
		send_word(make_word(CMD_WRITE, 63, 63, 1'b1));
		send_word(make_word(CMD_ADVANCE, 63, 63, 1'b1));
		send_word(make_word(CMD_READ, 1, 1, 1'b0));
		send_word(make_word(CMD_READ, 0, 0, 1'b0));
		send_word(make_word(CMD_READ, 63, 63, 1'b0));

		// Writing a dead cell breaks the block, and the next generation shows it.
		send_word(make_word(CMD_WRITE, 63, 63, 1'b0));
		send_word(make_word(CMD_READ, 63, 63, 1'b0));
		send_word(make_word(CMD_UNUSED, 0, 0, 1'b0));
		send_word(make_word(CMD_ADVANCE, 0, 0, 1'b0));

		// Let the block run dry once before the random traffic starts.
		drain();

		move_window();
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 3) begin
				tx_idle_pct = 61;
				rx_idle_pct = 38;
			end else if (i == 2 * RANDOM_WORDS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			send_word(random_command());
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.outstanding() != 0) begin
			$error("%0d response words never arrived", board.outstanding());
			board.errors++;
		end
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
src/lifeg_pkg.sv
src/lifeg_stream_if.sv
src/lifeg_ram.sv
src/lifeg_rule.sv
src/life_automaton_grid_unit.sv
src/lifeg_checker.sv
dv/tb_life_automaton_grid_unit.sv
